[rtl/kre_pkg.sv]
// types and constants shared by the keyboard report key event blocks
package kre_pkg;

  localparam int NUM_SOURCES = 8;
  localparam int KEY_SLOTS   = 6;
  localparam int IN_SLOTS    = 6;
  localparam int MASK_W      = 8;
  localparam int CODE_W      = 8;
  localparam int SRC_W       = 3;
  localparam int ROW_W       = $clog2(NUM_SOURCES);
  localparam int NUM_EV      = 2 * KEY_SLOTS;
  localparam int EV_W        = $clog2(NUM_EV);
  localparam logic [CODE_W-1:0] LOWEST_KEY = CODE_W'(4);

  typedef logic [KEY_SLOTS-1:0][CODE_W-1:0] row_t;
  typedef logic [IN_SLOTS-1:0][CODE_W-1:0]  slots_t;

  // even entries are releases of old slot codes, odd entries presses of new ones
  typedef struct packed {
    logic [ROW_W-1:0]                 src;
    logic [NUM_EV-1:0]                pend;
    logic [NUM_EV-1:0][CODE_W-1:0]    code;
  } ev_set_t;

  typedef struct packed {
    logic [SRC_W-1:0]  src;
    logic [CODE_W-1:0] code;
    logic              press;
    logic              last;
  } ev_word_t;

endpackage

[rtl/keyboard_report_key_events.sv]
// top level: keyboard report key press and release event extraction
//
// Each accepted word is one report (six slot codes) with a one-hot source mask
// on tuser. The report is registered, compared combinationally with the stored
// report of its source, and the store is updated as the report leaves the input
// register. Events then leave one per cycle while m_axis_tready is high, on the
// master side in slot order, release before press within a slot, with tlast on
// the final event of a report. A report yields at most 12 events; one with an
// invalid mask or no events loads nothing into the event register. An event word
// passes from the input register through the event register to the output word
// register. One new report is taken while earlier events are still draining and
// waits in the input register until the event register is free.
module keyboard_report_key_events (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // key_slot_0 .. key_slot_5, 8 bits each
  input  logic [kre_pkg::IN_SLOTS*kre_pkg::CODE_W-1:0] s_axis_tdata,
  // source_mask
  input  logic [kre_pkg::MASK_W-1:0]           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // event_code
  output logic [kre_pkg::CODE_W-1:0]           m_axis_tdata,
  // source_index [2:0], is_press [3]
  output logic [kre_pkg::SRC_W:0]              m_axis_tuser,
  output logic                                 m_axis_tlast
);

  logic                         a_valid;
  logic [kre_pkg::MASK_W-1:0]   a_mask;
  kre_pkg::slots_t              a_slots;
  logic                         a_done;
  logic [kre_pkg::ROW_W-1:0]    src;
  logic                         ok;
  kre_pkg::row_t                old_row;
  kre_pkg::row_t                new_row;
  kre_pkg::ev_set_t             ev;
  logic                         any_ev;
  logic                         emit_free;
  logic                         load;
  logic                         wr_en;
  kre_pkg::ev_word_t            out_word;

  assign any_ev        = ev.pend != '0;
  assign a_done        = !ok || !any_ev || emit_free;
  assign load          = a_valid && ok && any_ev && emit_free;
  assign wr_en         = a_valid && ok && a_done;
  assign s_axis_tready = !a_valid || a_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      a_mask  <= s_axis_tuser;
      a_slots <= s_axis_tdata;
    end
  end

  kre_store u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (src),
    .rd_row (old_row),
    .wr_en  (wr_en),
    .wr_idx (src),
    .wr_row (new_row)
  );

  kre_diff u_diff (
    .mask    (a_mask),
    .slots   (a_slots),
    .old_row (old_row),
    .src     (src),
    .ok      (ok),
    .new_row (new_row),
    .ev      (ev)
  );

  kre_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .ev_in     (ev),
    .free      (emit_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (out_word)
  );

  assign m_axis_tdata = out_word.code;
  assign m_axis_tuser = {out_word.press, out_word.src};
  assign m_axis_tlast = out_word.last;

  a_write_onehot: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> $onehot(a_mask))
    else $error("store written for a report with invalid mask");

endmodule

[rtl/kre_store.sv]
// previous report of each source, one row of slot codes per source
module kre_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [kre_pkg::ROW_W-1:0] rd_idx,
  output kre_pkg::row_t             rd_row,
  input  logic                      wr_en,
  input  logic [kre_pkg::ROW_W-1:0] wr_idx,
  input  kre_pkg::row_t             wr_row
);

  kre_pkg::row_t rows [kre_pkg::NUM_SOURCES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < kre_pkg::NUM_SOURCES; i++) begin
        rows[i] <= '0;
      end
    end else if (wr_en) begin
      rows[wr_idx] <= wr_row;
    end
  end

  assign rd_row = rows[rd_idx];

endmodule

[rtl/kre_diff.sv]
// mask decode and old/new report comparison for one registered report
module kre_diff (
  input  logic [kre_pkg::MASK_W-1:0] mask,
  input  kre_pkg::slots_t            slots,
  input  kre_pkg::row_t              old_row,
  output logic [kre_pkg::ROW_W-1:0]  src,
  output logic                       ok,
  output kre_pkg::row_t              new_row,
  output kre_pkg::ev_set_t           ev
);

  logic [kre_pkg::KEY_SLOTS-1:0] old_hit;
  logic [kre_pkg::KEY_SLOTS-1:0] new_hit;

  always_comb begin
    src = '0;
    for (int i = 0; i < kre_pkg::NUM_SOURCES && i < kre_pkg::MASK_W; i++) begin
      if (mask[i]) begin
        src = i[kre_pkg::ROW_W-1:0];
      end
    end
    ok = $onehot(mask);
    for (int i = kre_pkg::NUM_SOURCES; i < kre_pkg::MASK_W; i++) begin
      if (mask[i]) begin
        ok = 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < kre_pkg::KEY_SLOTS; i++) begin
      new_row[i] = (i < kre_pkg::IN_SLOTS) ? slots[i] : '0;
    end
  end

  // old_hit: old code still present in new report; new_hit: new code was already held
  always_comb begin
    for (int i = 0; i < kre_pkg::KEY_SLOTS; i++) begin
      old_hit[i] = 1'b0;
      new_hit[i] = 1'b0;
      for (int k = 0; k < kre_pkg::KEY_SLOTS; k++) begin
        if (old_row[i] == new_row[k]) begin
          old_hit[i] = 1'b1;
        end
        if (new_row[i] == old_row[k]) begin
          new_hit[i] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    ev.src = src;
    for (int i = 0; i < kre_pkg::KEY_SLOTS; i++) begin
      ev.code[2*i]   = old_row[i];
      ev.code[2*i+1] = new_row[i];
      ev.pend[2*i]   = (old_row[i] >= kre_pkg::LOWEST_KEY) && !old_hit[i];
      ev.pend[2*i+1] = (new_row[i] >= kre_pkg::LOWEST_KEY) && !new_hit[i];
    end
  end

endmodule

[rtl/kre_emit.sv]
// pending event register and output word register
module kre_emit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  kre_pkg::ev_set_t      ev_in,
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output kre_pkg::ev_word_t     out_word
);

  logic                         busy;
  kre_pkg::ev_set_t             cur;
  logic [kre_pkg::NUM_EV-1:0]   pend_next;
  logic [kre_pkg::EV_W-1:0]     sel;
  logic                         found;
  logic                         out_free;
  logic                         pop;
  logic                         pop_last;

  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = 0; i < kre_pkg::NUM_EV; i++) begin
      if (cur.pend[i] && !found) begin
        sel   = i[kre_pkg::EV_W-1:0];
        found = 1'b1;
      end
    end
    pend_next      = cur.pend;
    pend_next[sel] = 1'b0;
  end

  assign out_free = !out_valid || out_ready;
  assign pop      = busy && out_free;
  assign pop_last = pend_next == '0;
  assign free     = !busy || (pop && pop_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (pop && pop_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= ev_in;
    end else if (pop) begin
      cur.pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word.src   <= kre_pkg::SRC_W'(cur.src);
      out_word.code  <= cur.code[sel];
      out_word.press <= sel[0];
      out_word.last  <= pop_last;
    end
  end

  a_busy_pending: assert property (@(posedge clk) disable iff (rst)
    busy |-> cur.pend != '0)
    else $error("pending register busy with no event left");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free && ev_in.pend != '0)
    else $error("event set loaded over unfinished one");

  a_out_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.code >= kre_pkg::LOWEST_KEY)
    else $error("output word carries a non-key code");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

endmodule
